/* hw/rtl/dtwp_pkg.sv */
// Shared types and constants for the disparity to world point pipeline.
package dtwp_pkg;

	localparam int DIV_NW = 45;
	localparam int DIV_DW = 16;
	localparam int Z_W    = 29;
	localparam int D_W    = 18;
	localparam int P_W    = 47;
	localparam int X_W    = 46;
	localparam int ACC_W  = 66;

	localparam logic [15:0] MIN_DISP_RAW = 16'd160;
	localparam logic [31:0] GRAY_SAT_Z   = 32'd230276;
	localparam logic [15:0] RECIP7       = 16'd9363;
	localparam logic [15:0] RECIP3       = 16'd21846;

	localparam logic [7:0] REG_DEPTH_NUM = 8'd0;
	localparam logic [7:0] REG_FOCAL_X   = 8'd1;
	localparam logic [7:0] REG_FOCAL_Y   = 8'd2;
	localparam logic [7:0] REG_CENTER_X  = 8'd3;
	localparam logic [7:0] REG_CENTER_Y  = 8'd4;
	localparam logic [7:0] REG_ROW0      = 8'd5;
	localparam logic [7:0] REG_ROW1      = 8'd6;
	localparam logic [7:0] REG_ROW2      = 8'd7;

	typedef struct packed {
		logic [31:0] depth_num;
		logic [15:0] focal_x;
		logic [15:0] focal_y;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [63:0] row0;
		logic [63:0] row1;
		logic [63:0] row2;
	} cfg_t;

	function automatic logic is_mult3(input logic [11:0] v);
		logic [27:0] prod;
		logic [13:0] rem;
		prod = {16'd0, v} * {12'd0, RECIP3};
		rem = {2'b0, v} - 14'(3 * {2'b0, prod[27:16]});
		return rem == 14'd0;
	endfunction

endpackage

/* hw/rtl/disparity_to_world_point.sv */
// Top level of the disparity to world point reprojection pipeline.
// Accepts one disparity sample per clock and emits one world point per kept
// sample (column and row multiples of 3, disparity above 10.0). Each sample
// passes in turn through the two 45-stage pipelined dividers in series (depth,
// then camera x/y). The whole pipeline advances whenever the output register
// is empty or being taken, so s_tready falls only while a result is held.
// Configuration writes are taken every cycle and must be made while idle.
module disparity_to_world_point (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // column[11:0], pixel_row[23:12], disparity[39:24]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,   // world_x[31:0], world_y[63:32], world_z[95:64],
	                                 // gray_level[103:96]
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import dtwp_pkg::*;

	cfg_t cfg;
	logic en;
	logic [11:0] col, prow;
	logic [15:0] disp;

	assign cfg_ready = 1'b1;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign col  = s_tdata[11:0];
	assign prow = s_tdata[23:12];
	assign disp = s_tdata[39:24];

	dtwp_cfg u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg
	);

	// stage 1: filter and offsets
	logic v_s1;
	logic [DIV_NW-1:0] num_s1;
	logic [15:0] disp_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid && is_mult3(col) && is_mult3(prow)
			&& (disp > MIN_DISP_RAW);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= {9'd0, cfg.depth_num, 4'd0};
			disp_s1 <= disp;
			dx_s1   <= $signed({2'b0, col, 4'b0}) - $signed({2'b0, cfg.center_x});
			dy_s1   <= $signed({2'b0, prow, 4'b0}) - $signed({2'b0, cfg.center_y});
		end
	end

	// depth divider with side lines
	logic [DIV_NW-1:0] zq;
	logic [DIV_NW-1:0] vd1_q;
	logic signed [D_W-1:0] dxd_q [0:DIV_NW-1];
	logic signed [D_W-1:0] dyd_q [0:DIV_NW-1];

	dtwp_div u_div_z (.clk, .en, .dividend(num_s1), .divisor(disp_s1), .quotient(zq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd1_q <= '0;
		else if (en) vd1_q <= {vd1_q[DIV_NW-2:0], v_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxd_q[0] <= dx_s1;
			dyd_q[0] <= dy_s1;
			for (int i = 1; i < DIV_NW; i++) begin
				dxd_q[i] <= dxd_q[i-1];
				dyd_q[i] <= dyd_q[i-1];
			end
		end
	end

	// stage 2: depth register
	logic v_s2;
	logic [Z_W-1:0] z_s2;
	logic signed [D_W-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= vd1_q[DIV_NW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2  <= zq[Z_W-1:0];
			dx_s2 <= dxd_q[DIV_NW-1];
			dy_s2 <= dyd_q[DIV_NW-1];
		end
	end

	// stage 3: offset times depth
	logic v_s3;
	logic [Z_W-1:0] z_s3;
	logic signed [P_W-1:0] px_s3, py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3  <= z_s2;
			px_s3 <= P_W'(dx_s2) * P_W'($signed({1'b0, z_s2}));
			py_s3 <= P_W'(dy_s2) * P_W'($signed({1'b0, z_s2}));
		end
	end

	// stage 4: magnitudes for the focal dividers
	logic v_s4, sx_s4, sy_s4;
	logic [Z_W-1:0] z_s4;
	logic [DIV_NW-1:0] ax_s4, ay_s4;
	logic [P_W-1:0] nx, ny;

	assign nx = -px_s3;
	assign ny = -py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4  <= z_s3;
			sx_s4 <= px_s3[P_W-1];
			sy_s4 <= py_s3[P_W-1];
			ax_s4 <= px_s3[P_W-1] ? nx[DIV_NW-1:0] : px_s3[DIV_NW-1:0];
			ay_s4 <= py_s3[P_W-1] ? ny[DIV_NW-1:0] : py_s3[DIV_NW-1:0];
		end
	end

	logic [DIV_NW-1:0] xq, yq;
	logic [DIV_NW-1:0] vd2_q, sxd_q, syd_q;
	logic [Z_W-1:0] zd_q [0:DIV_NW-1];

	dtwp_div u_div_x (.clk, .en, .dividend(ax_s4), .divisor(cfg.focal_x), .quotient(xq));
	dtwp_div u_div_y (.clk, .en, .dividend(ay_s4), .divisor(cfg.focal_y), .quotient(yq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd2_q <= '0;
		else if (en) vd2_q <= {vd2_q[DIV_NW-2:0], v_s4};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxd_q <= {sxd_q[DIV_NW-2:0], sx_s4};
			syd_q <= {syd_q[DIV_NW-2:0], sy_s4};
			zd_q[0] <= z_s4;
			for (int i = 1; i < DIV_NW; i++) zd_q[i] <= zd_q[i-1];
		end
	end

	// stage 5: signed camera point
	logic v_s5;
	logic signed [X_W-1:0] x_s5, y_s5;
	logic [Z_W-1:0] z_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= vd2_q[DIV_NW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5 <= sxd_q[DIV_NW-1] ? -$signed({1'b0, xq}) : $signed({1'b0, xq});
			y_s5 <= syd_q[DIV_NW-1] ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
			z_s5 <= zd_q[DIV_NW-1];
		end
	end

	// transform, three stages
	logic signed [31:0] wx, wy, wz;
	logic [2:0] vt_q;

	dtwp_xform u_row0 (.clk, .en, .row(cfg.row0), .x(x_s5), .y(y_s5), .z(z_s5), .w(wx));
	dtwp_xform u_row1 (.clk, .en, .row(cfg.row1), .x(x_s5), .y(y_s5), .z(z_s5), .w(wy));
	dtwp_xform u_row2 (.clk, .en, .row(cfg.row2), .x(x_s5), .y(y_s5), .z(z_s5), .w(wz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vt_q <= '0;
		else if (en) vt_q <= {vt_q[1:0], v_s5};
	end

	// grey level: z*255 / (7*2^15), saturated
	logic v_s6, neg_s6, sat_s6;
	logic [25:0] gm_s6;
	logic signed [31:0] wx_s6, wy_s6, wz_s6;
	logic [26:0] gr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= vt_q[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s6  <= wx;
			wy_s6  <= wy;
			wz_s6  <= wz;
			neg_s6 <= wz[31];
			sat_s6 <= !wz[31] && ($unsigned(wz) >= GRAY_SAT_Z);
			gm_s6  <= {8'd0, wz[17:0]} * 26'd255;
		end
	end

	assign gr = {16'd0, gm_s6[25:15]} * {11'd0, RECIP7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[31:0]  <= wx_s6;
			m_tdata[63:32] <= wy_s6;
			m_tdata[95:64] <= wz_s6;
			if (neg_s6)      m_tdata[103:96] <= 8'd0;
			else if (sat_s6) m_tdata[103:96] <= 8'd255;
			else             m_tdata[103:96] <= gr[23:16];
		end
	end
endmodule

/* hw/rtl/dtwp_cfg.sv */
// Configuration register file; focal lengths of zero read as one.
module dtwp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output dtwp_pkg::cfg_t     cfg
);
	import dtwp_pkg::*;

	cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.depth_num <= '0;
			regs_q.focal_x   <= 16'd16;
			regs_q.focal_y   <= 16'd16;
			regs_q.center_x  <= '0;
			regs_q.center_y  <= '0;
			regs_q.row0      <= 64'h4000_0000_0000_0000;
			regs_q.row1      <= 64'h0000_4000_0000_0000;
			regs_q.row2      <= 64'h0000_0000_4000_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPTH_NUM: regs_q.depth_num <= cfg_data[31:0];
				REG_FOCAL_X:   regs_q.focal_x   <= cfg_data[15:0];
				REG_FOCAL_Y:   regs_q.focal_y   <= cfg_data[15:0];
				REG_CENTER_X:  regs_q.center_x  <= cfg_data[15:0];
				REG_CENTER_Y:  regs_q.center_y  <= cfg_data[15:0];
				REG_ROW0:      regs_q.row0      <= cfg_data;
				REG_ROW1:      regs_q.row1      <= cfg_data;
				REG_ROW2:      regs_q.row2      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg = regs_q;
		if (regs_q.focal_x == 16'd0) cfg.focal_x = 16'd1;
		if (regs_q.focal_y == 16'd0) cfg.focal_y = 16'd1;
	end
endmodule

/* hw/rtl/dtwp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module dtwp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dtwp_pkg::DIV_NW-1:0]   dividend,
	input  logic [dtwp_pkg::DIV_DW-1:0]   divisor,
	output logic [dtwp_pkg::DIV_NW-1:0]   quotient
);
	import dtwp_pkg::*;

	logic [DIV_DW-1:0] rem_p [0:DIV_NW];
	logic [DIV_NW-1:0] num_p [0:DIV_NW];
	logic [DIV_DW-1:0] dvs_p [0:DIV_NW];

	assign rem_p[0] = '0;
	assign num_p[0] = dividend;
	assign dvs_p[0] = divisor;

	for (genvar g = 0; g < DIV_NW; g++) begin : g_st
		logic [DIV_DW:0] trial;
		logic [DIV_DW:0] diff;
		assign trial = {rem_p[g], num_p[g][DIV_NW-1]};
		assign diff  = trial - {1'b0, dvs_p[g]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[g+1] <= diff[DIV_DW] ? trial[DIV_DW-1:0] : diff[DIV_DW-1:0];
				num_p[g+1] <= {num_p[g][DIV_NW-2:0], ~diff[DIV_DW]};
				dvs_p[g+1] <= dvs_p[g];
			end
		end
	end

	assign quotient = num_p[DIV_NW];
endmodule

/* hw/rtl/dtwp_xform.sv */
// One row of the rigid transform: products, sum, scale and saturate.
module dtwp_xform (
	input  logic                           clk,
	input  logic                           en,
	input  logic [63:0]                    row,
	input  logic signed [dtwp_pkg::X_W-1:0] x,
	input  logic signed [dtwp_pkg::X_W-1:0] y,
	input  logic [dtwp_pkg::Z_W-1:0]       z,
	output logic signed [31:0]             w
);
	import dtwp_pkg::*;

	logic signed [15:0] r0, r1, r2, t;
	logic signed [39:0] pxl_s1, pyl_s1;
	logic signed [38:0] pxh_s1, pyh_s1;
	logic signed [45:0] pz_s1;
	logic signed [15:0] t_s1;
	logic signed [ACC_W-1:0] acc_s2;
	logic signed [ACC_W-1:0] adj;
	logic signed [ACC_W-1:0] shr;

	assign r0 = row[63:48];
	assign r1 = row[47:32];
	assign r2 = row[31:16];
	assign t  = row[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s1 <= r0 * $signed({1'b0, x[22:0]});
			pxh_s1 <= r0 * $signed(x[X_W-1:23]);
			pyl_s1 <= r1 * $signed({1'b0, y[22:0]});
			pyh_s1 <= r1 * $signed(y[X_W-1:23]);
			pz_s1  <= r2 * $signed({1'b0, z});
			t_s1   <= t;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= (ACC_W'(pxh_s1) <<< 23) + ACC_W'(pxl_s1)
				+ (ACC_W'(pyh_s1) <<< 23) + ACC_W'(pyl_s1)
				+ ACC_W'(pz_s1) + (ACC_W'(t_s1) <<< 20);
		end
	end

	assign adj = acc_s2 + (acc_s2[ACC_W-1] ? ACC_W'(16383) : ACC_W'(0));
	assign shr = adj >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			if (shr > ACC_W'(64'sd2147483647))       w <= 32'sh7FFF_FFFF;
			else if (shr < -ACC_W'(64'sd2147483648)) w <= 32'sh8000_0000;
			else                                      w <= shr[31:0];
		end
	end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the disparity to world point pipeline.
`timescale 1ns / 1ps

module tb_top;
	import dtwp_pkg::*;

	typedef struct packed {
		logic [7:0]  gray;
		logic [31:0] wz;
		logic [31:0] wy;
		logic [31:0] wx;
	} point_t;

	class point_scoreboard;
		logic [31:0] depth_num;
		logic [15:0] fx, fy, cx, cy;
		logic [63:0] rows [3];
		point_t pending [$];
		int errors;

		function void reset_regs();
			depth_num = '0;
			fx = 16'd16;
			fy = 16'd16;
			cx = '0;
			cy = '0;
			rows[0] = 64'h4000_0000_0000_0000;
			rows[1] = 64'h0000_4000_0000_0000;
			rows[2] = 64'h0000_0000_4000_0000;
			errors = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [63:0] val);
			case (idx)
				REG_DEPTH_NUM: depth_num = val[31:0];
				REG_FOCAL_X:   fx = val[15:0];
				REG_FOCAL_Y:   fy = val[15:0];
				REG_CENTER_X:  cx = val[15:0];
				REG_CENTER_Y:  cy = val[15:0];
				REG_ROW0:      rows[0] = val;
				REG_ROW1:      rows[1] = val;
				REG_ROW2:      rows[2] = val;
				default: ;
			endcase
		endfunction

		function longint rotate(logic [63:0] r, longint px, longint py, longint pz);
			longint acc;
			acc = longint'($signed(r[63:48])) * px + longint'($signed(r[47:32])) * py
				+ longint'($signed(r[31:16])) * pz + longint'($signed(r[15:0])) * 1048576;
			acc = acc / 16384;
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
			if (acc < -64'sd2147483648) acc = -64'sd2147483648;
			return acc;
		endfunction

		function void note_sample(logic [11:0] col, logic [11:0] prow, logic [15:0] disp);
			longint z, x, y, w [3], g, dfx, dfy;
			point_t p;
			if (col % 3 != 0 || prow % 3 != 0 || disp <= MIN_DISP_RAW) return;
			dfx = fx == 16'd0 ? 64'sd1 : longint'(fx);
			dfy = fy == 16'd0 ? 64'sd1 : longint'(fy);
			z = longint'({depth_num, 4'b0}) / longint'(disp);
			x = ((longint'(col) * 16 - longint'(cx)) * z) / dfx;
			y = ((longint'(prow) * 16 - longint'(cy)) * z) / dfy;
			for (int i = 0; i < 3; i++) w[i] = rotate(rows[i], x, y, z);
			g = (w[2] * 510) / (7 * 65536);
			if (g < 0) g = 0;
			if (g > 255) g = 255;
			p.wx = w[0][31:0];
			p.wy = w[1][31:0];
			p.wz = w[2][31:0];
			p.gray = g[7:0];
			pending = {pending, p};
		endfunction

		function void check_point(point_t got);
			point_t e;
			if (pending.size() == 0) begin
				$error("unexpected point %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.wx !== e.wx) begin
				$error("world_x exp %h got %h", e.wx, got.wx);
				errors++;
			end
			if (got.wy !== e.wy) begin
				$error("world_y exp %h got %h", e.wy, got.wy);
				errors++;
			end
			if (got.wz !== e.wz) begin
				$error("world_z exp %h got %h", e.wz, got.wz);
				errors++;
			end
			if (got.gray !== e.gray) begin
				$error("gray_level exp %0d got %0d", e.gray, got.gray);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
	logic [39:0] s_tdata;
	logic [103:0] m_tdata;
	logic [7:0] cfg_index;
	logic [63:0] cfg_data;
	point_scoreboard sb;
	bit calm, hold_off;
	longint cycles;

	disparity_to_world_point u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_point(m_tdata);

	// receiver: random stalls, calm stretch, one long hold-off
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) m_tready = 0;
			else m_tready = calm || $urandom_range(99) >= 32;
		end
	end

	// register writes wait until every kept transfer has left the block
	task automatic write_cfg(logic [7:0] idx, logic [63:0] val);
		@(negedge clk);
		s_tvalid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send(logic [11:0] col, logic [11:0] prow, logic [15:0] disp);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 32) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {disp, prow, col};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(col, prow, disp);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [11:0] grid(int lim);
		return 12'($urandom_range(lim / 3) * 3);
	endfunction

	function automatic logic [63:0] rand_row(bit sane, int diag);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (sane) begin
			r[63:16] = '0;
			r[63 - 16 * diag -: 16] = 16'h4000 + 16'($urandom_range(2047)) - 16'd1024;
			r[15:0] = 16'($urandom_range(4095)) - 16'd2048;
		end
		return r;
	endfunction

	task automatic random_items(int n);
		logic [15:0] d;
		for (int i = 0; i < n; i++) begin
			d = $urandom_range(9) < 7 ? 16'($urandom_range(4000, 161)) : 16'($urandom);
			if ($urandom_range(9) < 7) send(grid(4095), grid(4095), d);
			else send(12'($urandom), 12'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		hold_off = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset config, then directed corners
		send(12'd0, 12'd0, 16'hFFFF);
		write_cfg(REG_DEPTH_NUM, 64'h0010_0000);
		write_cfg(REG_FOCAL_X, 64'd8000);
		write_cfg(REG_FOCAL_Y, 64'd8000);
		write_cfg(REG_CENTER_X, 64'd10240);
		write_cfg(REG_CENTER_Y, 64'd7680);
		send(12'd0, 12'd0, 16'd161);
		send(12'd0, 12'd0, 16'd160);
		send(12'd0, 12'd0, 16'd0);
		send(12'd4095, 12'd4095, 16'hFFFF);
		send(12'd4094, 12'd0, 16'd400);
		send(12'd0, 12'd4093, 16'd400);
		send(12'd3, 12'd3, 16'd400);
		send(12'd4095, 12'd0, 16'd161);
		send(12'd0, 12'd4095, 16'd161);
		send(12'hAAA, 12'h555, 16'hAAAA);
		send(12'h555, 12'hAAA, 16'h5555);
		write_cfg(REG_ROW2, 64'h0000_0000_7FFF_7FFF);
		send(12'd0, 12'd0, 16'd161);
		write_cfg(REG_ROW2, 64'h0000_0000_C000_8000);
		send(12'd0, 12'd0, 16'd161);
		write_cfg(REG_DEPTH_NUM, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(REG_FOCAL_X, 64'd0);
		write_cfg(REG_FOCAL_Y, 64'hFFFF);
		write_cfg(REG_CENTER_X, 64'hFFFF);
		write_cfg(REG_CENTER_Y, 64'd0);
		write_cfg(REG_ROW0, 64'h7FFF_8000_7FFF_7FFF);
		write_cfg(REG_ROW1, 64'h8000_8000_8000_8000);
		write_cfg(REG_ROW2, 64'h7FFF_7FFF_7FFF_7FFF);
		write_cfg(8'hFF, 64'h1234);
		send(12'd0, 12'd4095, 16'd161);
		send(12'd4095, 12'd0, 16'd161);
		send(12'd2049, 12'd3000, 16'hFFFF);
		drain();

		// plausible camera, long no-stall stretch, then receiver hold-off
		write_cfg(REG_DEPTH_NUM, 64'($urandom_range(32'h0100_0000, 32'h0001_0000)));
		write_cfg(REG_FOCAL_X, 64'($urandom_range(16000, 4000)));
		write_cfg(REG_FOCAL_Y, 64'($urandom_range(16000, 4000)));
		write_cfg(REG_CENTER_X, 64'($urandom_range(30000)));
		write_cfg(REG_CENTER_Y, 64'($urandom_range(30000)));
		write_cfg(REG_ROW0, rand_row(1, 0));
		write_cfg(REG_ROW1, rand_row(1, 1));
		write_cfg(REG_ROW2, rand_row(1, 2));
		calm = 1;
		random_items(100);
		calm = 0;
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_items(150);
		join
		drain();

		// random registers (sane rows in the last phase), zero focal included
		for (int ph = 0; ph < 3; ph++) begin
			write_cfg(REG_DEPTH_NUM, {$urandom, $urandom});
			write_cfg(REG_FOCAL_X, ph == 0 ? 64'd0 : 64'($urandom));
			write_cfg(REG_FOCAL_Y, 64'($urandom));
			write_cfg(REG_CENTER_X, 64'($urandom));
			write_cfg(REG_CENTER_Y, 64'($urandom));
			write_cfg(REG_ROW0, rand_row(ph == 2, 0));
			write_cfg(REG_ROW1, rand_row(ph == 2, 1));
			write_cfg(REG_ROW2, rand_row(ph == 2, 2));
			random_items(120);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
